// ===== rtl/core/lgi_pkg.sv =====
// Shared types and constants of the Lagrange interpolator.
package lgi_pkg;

	// Field widths of the words on the ports
	localparam int VALUE_WIDTH = 32;
	localparam int INDEX_W     = 4;
	localparam int COUNT_W     = 5;
	localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd4;

	// Datapath widths of the shared multiply-divide unit
	localparam int MAG_W      = 32;
	localparam int WEIGHT_W   = 63;
	localparam int PROD_W     = WEIGHT_W + MAG_W;
	localparam int SUM_W      = 64;
	localparam int DIV_CNT_W  = 6;

	// Clip limits of weight and term magnitudes
	localparam logic [WEIGHT_W-1:0] WEIGHT_CAP = 63'd1 << 62;
	localparam logic [WEIGHT_W-1:0] TERM_CAP   = 63'd1 << 56;

	typedef enum logic {
		MODE_LOAD = 1'b0,
		MODE_EVAL = 1'b1
	} mode_t;

	typedef struct packed {
		mode_t                     mode;
		logic [INDEX_W-1:0]        point_index;
		logic signed [VALUE_WIDTH-1:0] x_value;
		logic signed [VALUE_WIDTH-1:0] y_value;
	} cmd_word_t;

	typedef struct packed {
		logic signed [VALUE_WIDTH-1:0] interp_value;
		logic                          bad_nodes;
		logic                          overflow;
	} rsp_word_t;

	// Operations of the multiply-divide unit
	typedef enum logic {
		MD_FACTOR = 1'b0,
		MD_TERM   = 1'b1
	} md_op_t;

	typedef struct packed {
		logic   start;
		md_op_t op;
	} md_ctl_t;

	typedef struct packed {
		logic done;
		logic clip;
	} md_sts_t;

endpackage

// ===== rtl/core/lgi_node_store.sv =====
// Node store: abscissa and ordinate memories with registered reads.
module lgi_node_store #(
	parameter int MAX_POINTS = 16,
	parameter int IDX_W      = 4
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [IDX_W-1:0]                      waddr,
	input  logic signed [lgi_pkg::VALUE_WIDTH-1:0] wx,
	input  logic signed [lgi_pkg::VALUE_WIDTH-1:0] wy,
	input  logic [IDX_W-1:0]                      raddr_i,
	input  logic [IDX_W-1:0]                      raddr_j,
	output logic signed [lgi_pkg::VALUE_WIDTH-1:0] rd_xi,
	output logic signed [lgi_pkg::VALUE_WIDTH-1:0] rd_xj,
	output logic signed [lgi_pkg::VALUE_WIDTH-1:0] rd_yi
);

	logic signed [lgi_pkg::VALUE_WIDTH-1:0] x_mem [MAX_POINTS];
	logic signed [lgi_pkg::VALUE_WIDTH-1:0] y_mem [MAX_POINTS];

	// Write one node per load word
	always_ff @(posedge clk) begin
		if (we) begin
			x_mem[waddr] <= wx;
			y_mem[waddr] <= wy;
		end
	end

	// Read both abscissae of the current pair and the ordinate of the term node
	always_ff @(posedge clk) begin
		rd_xi <= x_mem[raddr_i];
		rd_xj <= x_mem[raddr_j];
		rd_yi <= y_mem[raddr_i];
	end

endmodule

// ===== rtl/core/lgi_muldiv.sv =====
// Shared multiply-divide unit: split multiply, bit-serial divide or fraction shift, with clipping.
module lgi_muldiv #(
	parameter int FRAC_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  lgi_pkg::md_ctl_t               ctl,
	input  logic [lgi_pkg::WEIGHT_W-1:0]   a_mag,
	input  logic [lgi_pkg::MAG_W-1:0]      b_mag,
	input  logic [lgi_pkg::MAG_W-1:0]      d_mag,
	output lgi_pkg::md_sts_t               sts,
	output logic [lgi_pkg::WEIGHT_W-1:0]   result
);

	localparam int WW = lgi_pkg::WEIGHT_W;
	localparam int MW = lgi_pkg::MAG_W;
	localparam int PW = lgi_pkg::PROD_W;
	localparam int CW = lgi_pkg::DIV_CNT_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL_LO,
		S_MUL_HI,
		S_SUM,
		S_EVAL,
		S_DIV,
		S_FIN
	} state_t;

	state_t              state_q;
	lgi_pkg::md_op_t     op_q;
	logic [WW-1:0]       a_q;
	logic [MW-1:0]       b_q;
	logic [MW-1:0]       d_q;
	logic [2*MW-1:0]     lo_q;
	logic [WW-1:0]       hi_q;
	logic [PW-1:0]       prod_q;
	logic [MW-1:0]       rem_q;
	logic [WW-1:0]       quo_q;
	logic [CW-1:0]       cnt_q;
	logic [WW-1:0]       result_q;
	logic                done_q;
	logic                clip_q;

	logic [MW-1:0]       mul_a;
	logic [2*MW-1:0]     mul_p;
	logic [PW-1:0]       shifted;
	logic [MW:0]         cur;
	logic [MW:0]         cur_sub;
	logic                qbit;
	logic                early_fin;

	// One multiplier, fed with the low or the high limb of the weight
	assign mul_a = (state_q == S_MUL_LO) ? a_q[MW-1:0] : {1'b0, a_q[WW-1:MW]};
	assign mul_p = {{MW{1'b0}}, mul_a} * {{MW{1'b0}}, b_q};

	// Term scaling drops the fraction bits
	assign shifted = prod_q >> FRAC_BITS;

	// One restoring divide step
	assign cur     = {rem_q, quo_q[WW-1]};
	assign cur_sub = cur - {1'b0, d_q};
	assign qbit    = (cur >= {1'b0, d_q});

	// A term, or a factor whose quotient reaches 2^63, ends without the divide
	assign early_fin = (op_q == lgi_pkg::MD_TERM) || (prod_q[PW-1:WW] >= d_q);

	// Sequence multiply, combine, check and divide
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
			clip_q  <= 1'b0;
		end else begin
			done_q <= (state_q == S_FIN) || ((state_q == S_EVAL) && early_fin);
			unique case (state_q)
				S_IDLE: begin
					if (ctl.start) begin
						op_q    <= ctl.op;
						a_q     <= a_mag;
						b_q     <= b_mag;
						d_q     <= d_mag;
						state_q <= S_MUL_LO;
					end
				end
				S_MUL_LO: begin
					lo_q    <= mul_p;
					state_q <= S_MUL_HI;
				end
				S_MUL_HI: begin
					hi_q    <= mul_p[WW-1:0];
					state_q <= S_SUM;
				end
				S_SUM: begin
					prod_q[MW-1:0]  <= lo_q[MW-1:0];
					prod_q[PW-1:MW] <= hi_q + {{(WW-MW){1'b0}}, lo_q[2*MW-1:MW]};
					state_q         <= S_EVAL;
				end
				S_EVAL: begin
					if (op_q == lgi_pkg::MD_TERM) begin
						clip_q   <= (shifted > {{MW{1'b0}}, lgi_pkg::TERM_CAP});
						result_q <= (shifted > {{MW{1'b0}}, lgi_pkg::TERM_CAP}) ?
							lgi_pkg::TERM_CAP : shifted[WW-1:0];
						state_q  <= S_IDLE;
					end else if (prod_q[PW-1:WW] >= d_q) begin
						// quotient reaches 2^63: far above the weight cap
						clip_q   <= 1'b1;
						result_q <= lgi_pkg::WEIGHT_CAP;
						state_q  <= S_IDLE;
					end else begin
						rem_q   <= prod_q[PW-1:WW];
						quo_q   <= prod_q[WW-1:0];
						cnt_q   <= '0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					rem_q <= qbit ? cur_sub[MW-1:0] : cur[MW-1:0];
					quo_q <= {quo_q[WW-2:0], qbit};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(WW - 1)) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					clip_q   <= (quo_q > lgi_pkg::WEIGHT_CAP);
					result_q <= (quo_q > lgi_pkg::WEIGHT_CAP) ? lgi_pkg::WEIGHT_CAP : quo_q;
					state_q  <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign sts.done = done_q;
	assign sts.clip = clip_q;
	assign result   = result_q;

endmodule

// ===== rtl/core/lagrange_interpolator.sv =====
// Lagrange interpolator top level: command sequencer, node store and shared arithmetic unit.
//
// Usage. Command words arrive on cmd_valid/cmd_ready. A load word (mode 0) writes the
// abscissa and ordinate into node slot point_index and returns nothing. An evaluate word
// (mode 1) returns one word on rsp_valid/rsp_ready: the interpolating polynomial through
// nodes 0 .. n-1 at x_value, with n the point_count register clamped to 1 .. MAX_POINTS.
// point_count is to be written through cfg_we/cfg_wdata only while idle; the block leaves
// this to the user. Each weight factor runs through the bit-serial divider in the shared
// multiply-divide unit unless its quotient reaches 2^63. A pair of equal abscissae ends
// the walk at once with bad_nodes set. cmd_ready is high only while no evaluation runs.
// A finished word waits in the output register; the next command is taken meanwhile,
// and a following evaluation holds its own word until the receiver takes the first.
// Reset clears the sequencer, the output valid flag and sets point_count to 4; the node
// store is not cleared and every used slot must be loaded before an evaluation.
module lagrange_interpolator #(
	parameter int MAX_POINTS = 16,
	parameter int FRAC_BITS  = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmd_valid,
	output logic                          cmd_ready,
	input  lgi_pkg::cmd_word_t            cmd_word,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output lgi_pkg::rsp_word_t            rsp_word,
	input  logic                          cfg_we,
	input  logic [lgi_pkg::COUNT_W-1:0]   cfg_wdata
);

	localparam int IDX_W = $clog2(MAX_POINTS);
	localparam int CNT_W = $clog2(MAX_POINTS + 1);
	localparam int VW    = lgi_pkg::VALUE_WIDTH;
	localparam int WW    = lgi_pkg::WEIGHT_W;
	localparam int MW    = lgi_pkg::MAG_W;
	localparam int SW    = lgi_pkg::SUM_W;
	localparam logic [WW-1:0] WEIGHT_ONE = 63'd1 << FRAC_BITS;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_TERM_START,
		ST_FETCH,
		ST_READ,
		ST_ISSUE,
		ST_WAIT_F,
		ST_TERM,
		ST_WAIT_T,
		ST_FINISH
	} state_t;

	state_t                      state_q;
	logic [lgi_pkg::COUNT_W-1:0] point_count_q;
	logic [CNT_W-1:0]            n_q;
	logic [CNT_W-1:0]            i_q;
	logic [CNT_W-1:0]            j_q;
	logic signed [VW-1:0]        x_q;
	logic signed [VW:0]          dn_q;
	logic signed [VW:0]          dd_q;
	logic [WW-1:0]               wm_q;
	logic                        neg_q;
	logic                        wclip_q;
	logic                        yi_nz_q;
	logic signed [SW-1:0]        sum_q;
	logic                        ovf_q;
	logic                        bad_q;
	logic                        rsp_valid_q;
	lgi_pkg::rsp_word_t          rsp_word_q;

	logic                        cmd_take;
	logic                        store_we;
	logic signed [VW-1:0]        rd_xi;
	logic signed [VW-1:0]        rd_xj;
	logic signed [VW-1:0]        rd_yi;
	logic [VW:0]                 dn_neg;
	logic [VW:0]                 dd_neg;
	logic [VW-1:0]               yi_neg;
	logic [MW-1:0]               dn_mag;
	logic [MW-1:0]               dd_mag;
	logic [MW-1:0]               yi_mag;
	lgi_pkg::md_ctl_t            md_ctl;
	lgi_pkg::md_sts_t            md_sts;
	logic [WW-1:0]               md_result;
	logic [SW-1:0]               tm_ext;
	logic [SW-1:0]               tm_neg;
	logic [CNT_W-1:0]            i_next;
	logic [CNT_W-1:0]            n_clamp;
	logic                        sum_fits;
	lgi_pkg::rsp_word_t          final_word;

	assign cmd_ready = (state_q == ST_IDLE);
	assign cmd_take  = cmd_valid && cmd_ready;
	assign store_we  = cmd_take && (cmd_word.mode == lgi_pkg::MODE_LOAD) &&
		(32'(cmd_word.point_index) < 32'(MAX_POINTS));

	// Hold the node count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= lgi_pkg::COUNT_RESET;
		end else if (cfg_we) begin
			point_count_q <= cfg_wdata;
		end
	end

	// Clamp the count to 1 .. MAX_POINTS
	always_comb begin
		if (point_count_q == '0) begin
			n_clamp = CNT_W'(1);
		end else if (32'(point_count_q) > 32'(MAX_POINTS)) begin
			n_clamp = CNT_W'(MAX_POINTS);
		end else begin
			n_clamp = CNT_W'(point_count_q);
		end
	end

	lgi_node_store #(
		.MAX_POINTS (MAX_POINTS),
		.IDX_W      (IDX_W)
	) u_store (
		.clk     (clk),
		.we      (store_we),
		.waddr   (IDX_W'(cmd_word.point_index)),
		.wx      (cmd_word.x_value),
		.wy      (cmd_word.y_value),
		.raddr_i (i_q[IDX_W-1:0]),
		.raddr_j (j_q[IDX_W-1:0]),
		.rd_xi   (rd_xi),
		.rd_xj   (rd_xj),
		.rd_yi   (rd_yi)
	);

	// Magnitudes of the factor differences and of the ordinate
	assign dn_neg = -dn_q;
	assign dd_neg = -dd_q;
	assign yi_neg = -rd_yi;
	assign dn_mag = dn_q[VW] ? dn_neg[MW-1:0] : dn_q[MW-1:0];
	assign dd_mag = dd_q[VW] ? dd_neg[MW-1:0] : dd_q[MW-1:0];
	assign yi_mag = rd_yi[VW-1] ? yi_neg : rd_yi;

	// Start the shared unit on a factor or a term
	assign md_ctl.start = ((state_q == ST_ISSUE) && (dd_q != '0)) || (state_q == ST_TERM);
	assign md_ctl.op    = (state_q == ST_TERM) ? lgi_pkg::MD_TERM : lgi_pkg::MD_FACTOR;

	lgi_muldiv #(
		.FRAC_BITS (FRAC_BITS)
	) u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (md_ctl),
		.a_mag  (wm_q),
		.b_mag  ((state_q == ST_TERM) ? yi_mag : dn_mag),
		.d_mag  (dd_mag),
		.sts    (md_sts),
		.result (md_result)
	);

	assign tm_ext = {1'b0, md_result};
	assign tm_neg = -tm_ext;
	assign i_next = i_q + 1'b1;

	// Saturate the sum and form the result word
	assign sum_fits = (&sum_q[SW-1:VW-1]) || !(|sum_q[SW-1:VW-1]);
	always_comb begin
		if (bad_q) begin
			final_word.interp_value = '0;
			final_word.bad_nodes    = 1'b1;
			final_word.overflow     = 1'b0;
		end else if (sum_fits) begin
			final_word.interp_value = sum_q[VW-1:0];
			final_word.bad_nodes    = 1'b0;
			final_word.overflow     = ovf_q;
		end else begin
			final_word.interp_value = sum_q[SW-1] ? {1'b1, {(VW-1){1'b0}}} :
				{1'b0, {(VW-1){1'b1}}};
			final_word.bad_nodes    = 1'b0;
			final_word.overflow     = 1'b1;
		end
	end

	// Sequence the walk over node pairs and hold the output word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			// Raise valid on a finished word, drop it once the receiver takes the word
			if ((state_q == ST_FINISH) && (!rsp_valid_q || rsp_ready)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_take && (cmd_word.mode == lgi_pkg::MODE_EVAL)) begin
						x_q     <= cmd_word.x_value;
						n_q     <= n_clamp;
						i_q     <= '0;
						sum_q   <= '0;
						ovf_q   <= 1'b0;
						bad_q   <= 1'b0;
						state_q <= ST_TERM_START;
					end
				end
				ST_TERM_START: begin
					wm_q    <= WEIGHT_ONE;
					neg_q   <= 1'b0;
					wclip_q <= 1'b0;
					j_q     <= '0;
					state_q <= ST_FETCH;
				end
				ST_FETCH: begin
					if (j_q == n_q) begin
						state_q <= ST_TERM;
					end else if (j_q == i_q) begin
						j_q <= j_q + 1'b1;
					end else begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					dn_q    <= {x_q[VW-1], x_q} - {rd_xj[VW-1], rd_xj};
					dd_q    <= {rd_xi[VW-1], rd_xi} - {rd_xj[VW-1], rd_xj};
					state_q <= ST_ISSUE;
				end
				ST_ISSUE: begin
					if (dd_q == '0) begin
						// repeated abscissa: drop the walk
						bad_q   <= 1'b1;
						state_q <= ST_FINISH;
					end else begin
						state_q <= ST_WAIT_F;
					end
				end
				ST_WAIT_F: begin
					if (md_sts.done) begin
						wm_q    <= md_result;
						wclip_q <= wclip_q || md_sts.clip;
						neg_q   <= neg_q ^ (dn_q[VW] ^ dd_q[VW]);
						j_q     <= j_q + 1'b1;
						state_q <= ST_FETCH;
					end
				end
				ST_TERM: begin
					neg_q   <= neg_q ^ rd_yi[VW-1];
					yi_nz_q <= (rd_yi != '0);
					state_q <= ST_WAIT_T;
				end
				ST_WAIT_T: begin
					if (md_sts.done) begin
						sum_q <= sum_q + (neg_q ? tm_neg : tm_ext);
						ovf_q <= ovf_q || (yi_nz_q && (wclip_q || md_sts.clip));
						if (i_next == n_q) begin
							state_q <= ST_FINISH;
						end else begin
							i_q     <= i_next;
							state_q <= ST_TERM_START;
						end
					end
				end
				ST_FINISH: begin
					if (!rsp_valid_q || rsp_ready) begin
						rsp_word_q <= final_word;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_word  = rsp_word_q;

`ifndef SYNTHESIS
	a_bad_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_word_q.bad_nodes |->
			(rsp_word_q.interp_value == '0) && !rsp_word_q.overflow)
		else $error("bad-nodes word carries a value or an overflow flag");

	a_walk_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FETCH || state_q == ST_READ || state_q == ST_ISSUE ||
		 state_q == ST_WAIT_F) |-> (j_q <= n_q) && (i_q < n_q))
		else $error("node walk index beyond the node count");

	a_done_expected: assert property (@(posedge clk) disable iff (!arst_n)
		md_sts.done |-> (state_q == ST_WAIT_F || state_q == ST_WAIT_T))
		else $error("arithmetic unit finished while the sequencer was not waiting");

	a_start_once: assert property (@(posedge clk) disable iff (!arst_n)
		md_ctl.start |=> !md_ctl.start)
		else $error("arithmetic unit started on two cycles in a row");
`endif

endmodule

// ===== tb/lagrange_interpolator_test.sv =====
// Self-checking testbench of the Lagrange interpolator: directed and random words, scored live.
module lagrange_interpolator_test;

	localparam int NODES         = 16;
	localparam int FRAC          = 16;
	localparam int SEGMENT_ITEMS = 47;
	localparam int SETTLE_CYCLES = 64;
	localparam int STALL_LIMIT   = 100000;
	localparam int IDX_W         = lgi_pkg::INDEX_W;
	localparam int CNT_W         = lgi_pkg::COUNT_W;
	localparam int VW            = lgi_pkg::VALUE_WIDTH;
	localparam longint VAL_MAX   = 64'sh0000_0000_7FFF_FFFF;
	localparam longint VAL_MIN   = -64'sh0000_0000_8000_0000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_ready;
	lgi_pkg::cmd_word_t cmd_word = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	lgi_pkg::rsp_word_t rsp_word;
	logic cfg_we = 1'b0;
	logic [CNT_W-1:0] cfg_wdata = '0;

	// Shadow of the block: node store, its fill marks and the count register
	logic signed [VW-1:0] node_x [NODES];
	logic signed [VW-1:0] node_y [NODES];
	bit node_loaded [NODES];
	logic [CNT_W-1:0] count_setting = lgi_pkg::COUNT_RESET;
	lgi_pkg::rsp_word_t awaited_results [$];
	lgi_pkg::rsp_word_t oldest;

	int send_idle_pct = 0;
	int rcv_idle_pct = 0;
	int fault_count = 0;
	int quiet_cycles = 0;
	int n_loads = 0;
	int n_evals = 0;
	int n_checked = 0;
	int n_bad = 0;
	int n_ovf = 0;
	int n_cfg = 0;

	lagrange_interpolator #(.MAX_POINTS(NODES), .FRAC_BITS(FRAC)) dut (
		.clk,
		.arst_n,
		.cmd_valid,
		.cmd_ready,
		.cmd_word,
		.rsp_valid,
		.rsp_ready,
		.rsp_word,
		.cfg_we,
		.cfg_wdata
	);

	always #6 clk = ~clk;

	// Clamp the count register to the nodes in use
	function automatic int node_total();
		int n;
		n = int'(count_setting);
		if (n < 1) n = 1;
		if (n > NODES) n = NODES;
		return n;
	endfunction

	function automatic logic [63:0] magnitude(input longint v);
		return (v < 0) ? 64'(-v) : 64'(v);
	endfunction

	// Truncated a*b/d, clipped to cap
	function automatic logic [63:0] scaled_ratio(input logic [63:0] a, input logic [63:0] b,
			input logic [63:0] d, input logic [63:0] cap, output bit clipped);
		logic [127:0] q;
		q = ({64'd0, a} * {64'd0, b}) / {64'd0, d};
		clipped = (q > {64'd0, cap});
		return clipped ? cap : q[63:0];
	endfunction

	// Interpolated value at xq through the nodes in use
	function automatic lgi_pkg::rsp_word_t interpolate(input logic signed [VW-1:0] xq);
		lgi_pkg::rsp_word_t r;
		int n;
		logic [63:0] wm;
		logic [63:0] tm;
		longint dn;
		longint dd;
		longint yi;
		longint acc;
		bit neg;
		bit wclip;
		bit tclip;
		bit hit;
		bit ovf;
		r = '0;
		n = node_total();
		for (int i = 0; i < n; i++)
			for (int j = i + 1; j < n; j++)
				if (node_x[i] == node_x[j]) begin
					r.bad_nodes = 1'b1;
					return r;
				end
		acc = 0;
		ovf = 1'b0;
		for (int i = 0; i < n; i++) begin
			wm = 64'd1 << FRAC;
			neg = 1'b0;
			wclip = 1'b0;
			tclip = 1'b0;
			yi = longint'(node_y[i]);
			// build the weight one factor at a time
			for (int j = 0; j < n; j++) begin
				if (j != i) begin
					dn = longint'(xq) - longint'(node_x[j]);
					dd = longint'(node_x[i]) - longint'(node_x[j]);
					wm = scaled_ratio(wm, magnitude(dn), magnitude(dd),
						64'(lgi_pkg::WEIGHT_CAP), hit);
					wclip |= hit;
					if ((dn < 0) != (dd < 0)) neg = !neg;
				end
			end
			tm = scaled_ratio(wm, magnitude(yi), 64'd1 << FRAC, 64'(lgi_pkg::TERM_CAP), tclip);
			if (yi != 0 && (wclip || tclip)) ovf = 1'b1;
			if (yi < 0) neg = !neg;
			acc += neg ? -longint'(tm) : longint'(tm);
		end
		// saturate to the Q16.16 range
		if (acc > VAL_MAX) begin
			acc = VAL_MAX;
			ovf = 1'b1;
		end else if (acc < VAL_MIN) begin
			acc = VAL_MIN;
			ovf = 1'b1;
		end
		r.interp_value = acc[VW-1:0];
		r.overflow = ovf;
		return r;
	endfunction

	function automatic logic signed [VW-1:0] rand_q16();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return $signed($urandom_range(0, 32'h001F_FFFF)) - 32'sh0010_0000;
			2: return $signed($urandom_range(0, 32'h0000_1FFF)) - 32'sh0000_1000;
			default: begin
				case ($urandom_range(0, 4))
					0: return 32'sh7FFF_FFFF;
					1: return 32'sh8000_0000;
					2: return 32'sh0000_0000;
					3: return 32'sh0001_0000;
					default: return -32'sh0001_0000;
				endcase
			end
		endcase
	endfunction

	// Send one command word and fold it into the shadow at acceptance
	task automatic send_word(input lgi_pkg::cmd_word_t w);
		lgi_pkg::rsp_word_t r;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd_word <= w;
		do @(posedge clk); while (!cmd_ready);
		if (w.mode == lgi_pkg::MODE_LOAD) begin
			node_x[w.point_index] = w.x_value;
			node_y[w.point_index] = w.y_value;
			node_loaded[w.point_index] = 1'b1;
			n_loads++;
		end else begin
			r = interpolate(w.x_value);
			awaited_results.push_back(r);
			n_evals++;
			if (r.bad_nodes) n_bad++;
			if (r.overflow) n_ovf++;
		end
	endtask

	task automatic load_node(input int idx, input logic signed [VW-1:0] x,
			input logic signed [VW-1:0] y);
		lgi_pkg::cmd_word_t w;
		w.mode = lgi_pkg::MODE_LOAD;
		w.point_index = idx[IDX_W-1:0];
		w.x_value = x;
		w.y_value = y;
		send_word(w);
	endtask

	task automatic evaluate_at(input logic signed [VW-1:0] x);
		lgi_pkg::cmd_word_t w;
		w.mode = lgi_pkg::MODE_EVAL;
		w.point_index = IDX_W'($urandom_range(0, NODES - 1));
		w.x_value = x;
		w.y_value = $urandom;
		send_word(w);
	endtask

	// Drop valid, drain every outstanding result and let the block settle
	task automatic wait_idle();
		cmd_valid <= 1'b0;
		while (awaited_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_count(input logic [CNT_W-1:0] value);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		count_setting = value;
		n_cfg++;
	endtask

	// Reset count of four, checked before any write
	task automatic test_default_count();
		for (int i = 0; i < 4; i++)
			load_node(i, 32'(i) <<< FRAC, 32'(i * i) <<< FRAC);
		evaluate_at(32'sh0001_8000);
	endtask

	task automatic test_field_extremes();
		write_count(5'd2);
		load_node(0, 32'sh8000_0000, 32'sh7FFF_FFFF);
		load_node(1, 32'sh7FFF_FFFF, 32'sh8000_0000);
		evaluate_at(32'sh8000_0000);
		evaluate_at(32'sh7FFF_FFFF);
	endtask

	task automatic test_repeated_abscissa();
		write_count(5'd3);
		load_node(2, 32'sh8000_0000, 32'sh0000_0001);
		evaluate_at(32'sh0000_0000);
	endtask

	// Term clip on close nodes, then a plain saturation of the sum
	task automatic test_clipping();
		write_count(5'd2);
		load_node(0, 32'sh0000_0000, 32'sh7FFF_FFFF);
		load_node(1, 32'sh0000_0001, 32'sh0000_0001);
		evaluate_at(32'sh7FFF_FFFF);
		load_node(0, 32'sh0000_0000, 32'sh4000_0000);
		load_node(1, 32'sh0001_0000, 32'sh7FFF_FFFF);
		evaluate_at(32'sh0002_0000);
	endtask

	// A count of zero acts as one node
	task automatic test_count_floor();
		write_count(5'd0);
		evaluate_at(rand_q16());
	endtask

	// Segments of mixed words, the last one at a large count
	task automatic test_random_traffic(input int send_idle, input int recv_idle,
			input logic [CNT_W-1:0] large_count);
		lgi_pkg::cmd_word_t w;
		int n;
		int eval_pct;
		int dup_pct;
		int hole;
		int src;
		send_idle_pct = send_idle;
		rcv_idle_pct = recv_idle;
		for (int seg = 0; seg < 4; seg++) begin
			if (seg == 3) begin
				write_count(large_count);
				eval_pct = 10;
				dup_pct = 2;
			end else begin
				write_count(CNT_W'($urandom_range(1, 5)));
				eval_pct = 40;
				dup_pct = 12;
			end
			n = node_total();
			for (int k = 0; k < SEGMENT_ITEMS; k++) begin
				w.point_index = IDX_W'($urandom_range(0, NODES - 1));
				w.y_value = $urandom;
				hole = -1;
				for (int s = n - 1; s >= 0; s--)
					if (!node_loaded[s]) hole = s;
				if ($urandom_range(0, 99) < eval_pct && hole < 0) begin
					// query, sometimes right on a node
					w.mode = lgi_pkg::MODE_EVAL;
					if ($urandom_range(0, 99) < 15)
						w.x_value = node_x[$urandom_range(0, n - 1)];
					else
						w.x_value = rand_q16();
				end else begin
					w.mode = lgi_pkg::MODE_LOAD;
					if (hole >= 0 && $urandom_range(0, 99) < 50)
						w.point_index = hole[IDX_W-1:0];
					else if ($urandom_range(0, 99) < 70)
						w.point_index = IDX_W'($urandom_range(0, n - 1));
					src = int'($urandom_range(0, n - 1));
					if ($urandom_range(0, 99) < dup_pct && node_loaded[src])
						w.x_value = node_x[src];
					else
						w.x_value = rand_q16();
					w.y_value = rand_q16();
				end
				send_word(w);
			end
		end
	endtask

	// Take each result and score it against the oldest prediction
	always @(posedge clk) begin
		rsp_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
		if (arst_n && rsp_valid && rsp_ready) begin
			if (awaited_results.size() == 0) begin
				$error("result word with no evaluate outstanding: %h", rsp_word);
				fault_count++;
			end else begin
				oldest = awaited_results.pop_front();
				n_checked++;
				if (rsp_word.interp_value !== oldest.interp_value) begin
					$error("interp_value: expected %h, actual %h",
						oldest.interp_value, rsp_word.interp_value);
					fault_count++;
				end
				if (rsp_word.bad_nodes !== oldest.bad_nodes) begin
					$error("bad_nodes: expected %b, actual %b",
						oldest.bad_nodes, rsp_word.bad_nodes);
					fault_count++;
				end
				if (rsp_word.overflow !== oldest.overflow) begin
					$error("overflow: expected %b, actual %b",
						oldest.overflow, rsp_word.overflow);
					fault_count++;
				end
			end
		end
	end

	// End the run when no word moves for too long
	always @(posedge clk) begin
		if (!arst_n || (cmd_valid && cmd_ready) || (rsp_valid && rsp_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct = 29;
		rcv_idle_pct = 83;
		test_default_count();
		test_field_extremes();
		test_repeated_abscissa();
		test_clipping();
		test_count_floor();
		test_random_traffic(29, 83, 5'd31);
		test_random_traffic(83, 29, 5'd16);
		test_random_traffic(0, 0, CNT_W'($urandom_range(6, 30)));
		wait_idle();
		$display("covered %0d node loads and %0d evaluations over %0d count settings",
			n_loads, n_evals, n_cfg);
		$display("%0d results scored, %0d with repeated abscissae, %0d saturated or clipped",
			n_checked, n_bad, n_ovf);
		if (fault_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/lgi_pkg.sv
rtl/core/lgi_node_store.sv
rtl/core/lgi_muldiv.sv
rtl/core/lagrange_interpolator.sv
tb/lagrange_interpolator_test.sv
